[design/sbq_pkg.sv]
// Shared widths, codes and handshake types of the smoothed biquad filter.
package sbq_pkg;

    // Field and arithmetic widths
    localparam int SAMPLE_WIDTH   = 24;
    localparam int COEF_WIDTH     = 32;
    localparam int CFRAC          = COEF_WIDTH - 4;
    localparam int GUARD          = 5;
    localparam int DELAY_WIDTH    = 48;
    localparam int RATE_WIDTH     = 24;
    localparam int NUM_COEF       = 5;
    localparam int COEF_IDX_WIDTH = $clog2(NUM_COEF + 1);
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 32;

    // Glide product: 33-bit gap times 25-bit signed rate
    localparam int GAP_WIDTH   = COEF_WIDTH + 1;
    localparam int GPROD_WIDTH = GAP_WIDTH + RATE_WIDTH + 1;

    // Filter product and accumulator widths
    localparam int FPROD_WIDTH = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int PROD_SHIFT  = CFRAC - GUARD;
    localparam int PROD_WIDTH  = FPROD_WIDTH - PROD_SHIFT;
    localparam int ACC_WIDTH   = DELAY_WIDTH + 1;
    localparam int YPRE_WIDTH  = ACC_WIDTH - GUARD;

    localparam logic signed [COEF_WIDTH-1:0] COEF_ONE =
        {{(COEF_WIDTH - CFRAC - 1){1'b0}}, 1'b1, {CFRAC{1'b0}}};
    localparam logic [RATE_WIDTH-1:0] RATE_RESET = RATE_WIDTH'(16777);

    // Configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_B0   = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_B1   = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_B2   = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_A1   = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_A2   = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_EN   = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_RATE = 3'd6;

    // Coefficient slots, which are also the filter step numbers
    localparam logic [COEF_IDX_WIDTH-1:0] COEF_B0 = 3'd0;
    localparam logic [COEF_IDX_WIDTH-1:0] COEF_B1 = 3'd1;
    localparam logic [COEF_IDX_WIDTH-1:0] COEF_B2 = 3'd2;
    localparam logic [COEF_IDX_WIDTH-1:0] COEF_A1 = 3'd3;
    localparam logic [COEF_IDX_WIDTH-1:0] COEF_A2 = 3'd4;
    localparam logic [COEF_IDX_WIDTH-1:0] STEP_WB = 3'd5;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_in;
        logic                           clear_history;
        logic                           block_end;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_out;
        logic                           block_end_out;
    } t_out_item;

    typedef struct packed {
        logic                      accept;
        logic                      load;
        logic                      g_issue;
        logic                      g_upd;
        logic                      f_en;
        logic                      finish;
        logic [COEF_IDX_WIDTH-1:0] rd_idx;
        logic [COEF_IDX_WIDTH-1:0] wr_idx;
    } t_cmd;

    typedef struct packed {
        logic smooth_en;
    } t_sts;

endpackage

[design/sbq_ctrl.sv]
// Sequencer of the smoothed biquad filter: accept, glide or load, filter steps, write back.
module sbq_ctrl (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    input  sbq_pkg::t_sts i_sts,
    output sbq_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOAD  = 2'd1;
    localparam logic [1:0] S_GLIDE = 2'd2;
    localparam logic [1:0] S_FILT  = 2'd3;

    localparam logic [sbq_pkg::COEF_IDX_WIDTH-1:0] GLIDE_LAST =
        sbq_pkg::COEF_IDX_WIDTH'(sbq_pkg::NUM_COEF);

    logic [1:0]                           r_state, n_state;
    logic [sbq_pkg::COEF_IDX_WIDTH-1:0]   r_cnt, n_cnt;
    logic                                 r_out_valid, n_out_valid;
    sbq_pkg::t_cmd                        w_cmd;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.accept = 1'b1;
                    n_cnt        = '0;
                    n_state      = i_sts.smooth_en ? S_GLIDE : S_LOAD;
                end
            end
            S_LOAD: begin
                w_cmd.load = 1'b1;
                n_cnt      = '0;
                n_state    = S_FILT;
            end
            S_GLIDE: begin
                // issue slot cnt, write back slot cnt-1
                w_cmd.rd_idx  = r_cnt;
                w_cmd.wr_idx  = r_cnt - 1'b1;
                w_cmd.g_issue = (r_cnt != GLIDE_LAST);
                w_cmd.g_upd   = (r_cnt != '0);
                if (r_cnt == GLIDE_LAST) begin
                    n_cnt   = '0;
                    n_state = S_FILT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FILT: begin
                w_cmd.rd_idx = r_cnt;
                if (r_cnt == sbq_pkg::STEP_WB) begin
                    // hold until the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        w_cmd.f_en   = 1'b1;
                        w_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    w_cmd.f_en = 1'b1;
                    n_cnt      = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = w_cmd.finish | (r_out_valid & ~i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

[design/sbq_dp.sv]
// Datapath of the smoothed biquad filter: registers, coefficient store, two multipliers.
module sbq_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [sbq_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_index,
    input  logic [sbq_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data,
    input  sbq_pkg::t_in_item                    i_in_data,
    input  sbq_pkg::t_cmd                        i_cmd,
    output sbq_pkg::t_sts                        o_sts,
    output sbq_pkg::t_out_item                   o_out_data
);

    localparam int SW  = sbq_pkg::SAMPLE_WIDTH;
    localparam int CW  = sbq_pkg::COEF_WIDTH;
    localparam int DW  = sbq_pkg::DELAY_WIDTH;
    localparam int AW  = sbq_pkg::ACC_WIDTH;
    localparam int PW  = sbq_pkg::PROD_WIDTH;
    localparam int YW  = sbq_pkg::YPRE_WIDTH;
    localparam int NC  = sbq_pkg::NUM_COEF;

    localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW - 1){1'b1}}};
    localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW - 1){1'b0}}};
    localparam logic signed [DW-1:0] DELAY_MAX  = {1'b0, {(DW - 1){1'b1}}};
    localparam logic signed [DW-1:0] DELAY_MIN  = {1'b1, {(DW - 1){1'b0}}};
    localparam logic signed [AW-1:0] RND_HALF   = AW'(1) <<< (sbq_pkg::GUARD - 1);

    function automatic logic signed [SW-1:0] sat_sample(input logic signed [YW-1:0] v);
        logic signed [SW-1:0] r;
        if (v > YW'(SAMPLE_MAX)) begin
            r = SAMPLE_MAX;
        end else if (v < YW'(SAMPLE_MIN)) begin
            r = SAMPLE_MIN;
        end else begin
            r = SW'(v);
        end
        return r;
    endfunction

    function automatic logic signed [DW-1:0] sat_delay(input logic signed [AW:0] v);
        logic signed [DW-1:0] r;
        if (v > (AW + 1)'(DELAY_MAX)) begin
            r = DELAY_MAX;
        end else if (v < (AW + 1)'(DELAY_MIN)) begin
            r = DELAY_MIN;
        end else begin
            r = DW'(v);
        end
        return r;
    endfunction

    // Configuration and coefficient state
    logic signed [CW-1:0]                r_target [NC];
    logic signed [CW-1:0]                r_live   [NC];
    logic                                r_smooth_en;
    logic [sbq_pkg::RATE_WIDTH-1:0]      r_rate;
    logic signed [DW-1:0]                r_d1, r_d2;

    // Per-sample working registers
    logic signed [SW-1:0]                r_x, r_y;
    logic                                r_be;
    logic signed [CW-1:0]                r_gbase;
    logic signed [sbq_pkg::GPROD_WIDTH-1:0] r_gprod;
    logic signed [sbq_pkg::FPROD_WIDTH-1:0] r_fprod;
    logic signed [AW-1:0]                r_s1;
    logic signed [PW-1:0]                r_s2;
    sbq_pkg::t_out_item                  r_out;

    logic                                w_rd_ok;
    logic signed [CW-1:0]                w_cur_live, w_cur_tgt, w_live_new;
    logic signed [sbq_pkg::GAP_WIDTH-1:0]   w_gap;
    logic signed [sbq_pkg::GPROD_WIDTH-1:0] w_gprod;
    logic signed [SW-1:0]                w_fop;
    logic signed [sbq_pkg::FPROD_WIDTH-1:0] w_fprod;
    logic signed [PW-1:0]                w_p;
    logic signed [AW-1:0]                w_acc, w_rnd, w_s1;
    logic signed [YW-1:0]                w_ypre;
    logic signed [AW:0]                  w_n1;
    logic signed [PW:0]                  w_n2;

    // One read port into the coefficient store, shared by glide and filter
    always_comb begin
        w_rd_ok    = (i_cmd.rd_idx < sbq_pkg::COEF_IDX_WIDTH'(NC));
        w_cur_live = w_rd_ok ? r_live[i_cmd.rd_idx]   : '0;
        w_cur_tgt  = w_rd_ok ? r_target[i_cmd.rd_idx] : '0;
        w_gap      = sbq_pkg::GAP_WIDTH'(w_cur_tgt) - sbq_pkg::GAP_WIDTH'(w_cur_live);
        w_gprod    = w_gap * $signed({1'b0, r_rate});
        w_live_new = r_gbase + $signed(r_gprod[sbq_pkg::RATE_WIDTH +: CW]);

        w_fop   = (i_cmd.rd_idx inside {sbq_pkg::COEF_A1, sbq_pkg::COEF_A2})
                  ? r_y : r_x;
        w_fprod = w_cur_live * w_fop;
        w_p     = $signed(r_fprod[sbq_pkg::PROD_SHIFT +: PW]);

        w_acc  = AW'(w_p) + AW'(r_d1);
        w_rnd  = w_acc + RND_HALF;
        w_ypre = $signed(w_rnd[AW-1:sbq_pkg::GUARD]);
        w_s1   = AW'(w_p) + AW'(r_d2);
        w_n1   = (AW + 1)'(r_s1) - (AW + 1)'(w_p);
        w_n2   = (PW + 1)'(r_s2) - (PW + 1)'(w_p);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NC; i++) begin
                r_target[i] <= '0;
                r_live[i]   <= '0;
            end
            r_target[sbq_pkg::COEF_B0] <= sbq_pkg::COEF_ONE;
            r_live[sbq_pkg::COEF_B0]   <= sbq_pkg::COEF_ONE;
            r_smooth_en <= 1'b0;
            r_rate      <= sbq_pkg::RATE_RESET;
            r_d1        <= '0;
            r_d2        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sbq_pkg::REG_B0:   r_target[sbq_pkg::COEF_B0] <= i_cfg_data[CW-1:0];
                    sbq_pkg::REG_B1:   r_target[sbq_pkg::COEF_B1] <= i_cfg_data[CW-1:0];
                    sbq_pkg::REG_B2:   r_target[sbq_pkg::COEF_B2] <= i_cfg_data[CW-1:0];
                    sbq_pkg::REG_A1:   r_target[sbq_pkg::COEF_A1] <= i_cfg_data[CW-1:0];
                    sbq_pkg::REG_A2:   r_target[sbq_pkg::COEF_A2] <= i_cfg_data[CW-1:0];
                    sbq_pkg::REG_EN:   r_smooth_en <= i_cfg_data[0];
                    sbq_pkg::REG_RATE: r_rate <= i_cfg_data[sbq_pkg::RATE_WIDTH-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.load) begin
                for (int i = 0; i < NC; i++) begin
                    r_live[i] <= r_target[i];
                end
            end
            if (i_cmd.g_upd) begin
                r_live[i_cmd.wr_idx] <= w_live_new;
            end

            if (i_cmd.accept && i_in_data.clear_history) begin
                r_d1 <= '0;
                r_d2 <= '0;
            end
            if (i_cmd.f_en && i_cmd.rd_idx == sbq_pkg::COEF_A2) begin
                r_d1 <= sat_delay(w_n1);
            end
            if (i_cmd.f_en && i_cmd.rd_idx == sbq_pkg::STEP_WB) begin
                r_d2 <= DW'(w_n2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x  <= i_in_data.sample_in;
            r_be <= i_in_data.block_end;
        end
        if (i_cmd.g_issue) begin
            r_gbase <= w_cur_live;
            r_gprod <= w_gprod;
        end
        if (i_cmd.f_en) begin
            r_fprod <= w_fprod;
            case (i_cmd.rd_idx)
                sbq_pkg::COEF_B1: r_y  <= sat_sample(w_ypre);
                sbq_pkg::COEF_B2: r_s1 <= w_s1;
                sbq_pkg::COEF_A1: r_s2 <= w_p;
                default: ;
            endcase
        end
        if (i_cmd.finish) begin
            r_out.sample_out    <= r_y;
            r_out.block_end_out <= r_be;
        end
    end

    assign o_sts.smooth_en = r_smooth_en;
    assign o_out_data      = r_out;

endmodule

[design/smoothed_biquad_filter.sv]
// Top level of the smoothed biquad filter: sequencer plus datapath.
// One request is in flight at a time; the pace is set by the one shared glide
// multiplier (one coefficient a cycle) and the six steps through the one shared filter
// multiplier, the second half waiting on the output sample.
// Reset (synchronous, active low) restores the register defaults, b0 = 1.0, clears delays.
module smoothed_biquad_filter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write channel, always ready
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [sbq_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_index,
    input  logic [sbq_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data,
    // input sample requests
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  sbq_pkg::t_in_item                    i_in_data,
    // filtered sample results
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output sbq_pkg::t_out_item                   o_out_data
);

    // Per request the sequencer walks:
    //   accept   - capture sample and block-end mark, zero delays on clear_history
    //   load     - copy targets to live coefficients (smoothing off)
    //   glide    - per coefficient: gap * rate into a register, then add the
    //              top bits back onto the live value (smoothing on)
    //   filter   - b0*x, b1*x, b2*x, a1*y, a2*y through one multiplier; y is
    //              rounded and saturated from b0*x + delay_one, delay_one is
    //              refreshed after a1*y, delay_two after a2*y
    //   finish   - move y into the output register; stall here while the
    //              previous result is still waiting to be taken
    // The output register decouples the sides: a new request is accepted as
    // soon as the sequencer is back in idle, even with a result still pending.

    sbq_pkg::t_cmd w_cmd;
    sbq_pkg::t_sts w_sts;

    // writes are never refused; unknown indexes drop inside the datapath
    assign o_cfg_ready = 1'b1;

    sbq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    sbq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_data  (o_out_data)
    );

endmodule

[design/sbq_checker.sv]
// Port-level checks of the smoothed biquad filter and their bind to the top level.
module sbq_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input sbq_pkg::t_out_item                   o_out_data
);

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("pending result changed");

    // one request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while previous one still in flight");

    // a new result only shows up at the end of a request's processing
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared with no request in flight");

endmodule

bind smoothed_biquad_filter sbq_checker u_sbq_checker (.*);
